// File: design/hdr_pkg.sv
package hdr_pkg;

    // sample and field widths
    localparam int unsigned ADC_BITS   = 12;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned MODE_W     = 8;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned OC_W       = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    // arithmetic widths
    localparam int unsigned SUP_W    = 23;
    localparam int unsigned V_W      = SUP_W;
    localparam int unsigned VPROD_W  = SUP_W + ADC_BITS;
    localparam int unsigned VSQ_W    = 2 * V_W;
    localparam int unsigned TVSQ_W   = 24;
    localparam int unsigned NUM_W    = TVSQ_W + DUTY_W;
    localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

    localparam int unsigned SHORT_COUNT_DEF = 10;

    localparam logic [NUM_W-1:0]  SUPPLY_NUM  = NUM_W'(4997120);
    localparam logic [SUP_W-1:0]  SUPPLY_OFS  = SUP_W'(15);
    // squared target voltages, 3200 and 2700
    localparam logic [TVSQ_W-1:0] TV_SQ_HIGH   = TVSQ_W'(3200 * 3200);
    localparam logic [TVSQ_W-1:0] TV_SQ_NORMAL = TVSQ_W'(2700 * 2700);

    localparam logic [OC_W-1:0] OC_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_BOOST  = 8'h80;
    localparam logic [MODE_W-1:0] MODE_NORMAL = 8'h40;
    localparam logic [MODE_W-1:0] MODE_ECO1   = 8'h01;
    localparam logic [MODE_W-1:0] MODE_ZERO   = 8'h00;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUTY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THR  = 2'd3;

    localparam logic [DUTY_W-1:0]   FULL_DUTY_RST  = 8'd200;
    localparam logic [DUTY_W-1:0]   MIN_DUTY_RST   = 8'd20;
    localparam logic [DUTY_W-1:0]   DUTY_SCALE_RST = 8'd200;
    localparam logic [ADC_BITS-1:0] SHORT_THR_RST  = ADC_BITS'(2050);

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [MODE_W-1:0]   mode;
        logic                ch1_active;
        logic                ch2_active;
        logic [ADC_BITS-1:0] ch1_sample;
        logic [ADC_BITS-1:0] ch2_sample;
        logic [ADC_BITS-1:0] ref_sample;
        logic                regulate_now;
    } t_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_ch1;
        logic [DUTY_W-1:0] duty_ch2;
        logic              short_detected;
        logic              load_found;
        logic              firing;
    } t_result;

    typedef struct packed {
        logic take;
        logic decide;
        logic sup_start;
        logic sup_latch;
        logic mul_v;
        logic mul_sq;
        logic div_start;
        logic write_duty;
        logic push;
        logic ch;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic ch1_act;
        logic ch2_act;
        logic v_zero;
        logic div_done;
    } t_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SUP,
        ST_SUP_WAIT,
        ST_MUL_V,
        ST_MUL_SQ,
        ST_DIV,
        ST_DIV_WAIT,
        ST_WRITE,
        ST_PUSH
    } t_state;

endpackage

// File: design/hdr_item_if.sv
interface hdr_item_if import hdr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [MODE_W-1:0]   mode;
    logic                ch1_active;
    logic                ch2_active;
    logic [ADC_BITS-1:0] ch1_sample;
    logic [ADC_BITS-1:0] ch2_sample;
    logic [ADC_BITS-1:0] ref_sample;
    logic                regulate_now;

    modport source (
        output valid, op, mode, ch1_active, ch2_active, ch1_sample, ch2_sample,
               ref_sample, regulate_now,
        input  ready
    );
    modport sink (
        input  valid, op, mode, ch1_active, ch2_active, ch1_sample, ch2_sample,
               ref_sample, regulate_now,
        output ready
    );
endinterface

// File: design/hdr_result_if.sv
interface hdr_result_if import hdr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_ch1;
    logic [DUTY_W-1:0] duty_ch2;
    logic              short_detected;
    logic              load_found;
    logic              firing;

    modport source (
        output valid, duty_ch1, duty_ch2, short_detected, load_found, firing,
        input  ready
    );
    modport sink (
        input  valid, duty_ch1, duty_ch2, short_detected, load_found, firing,
        output ready
    );
endinterface

// File: design/hdr_div.sv
module hdr_div import hdr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [VSQ_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [VSQ_W-1:0]     r_rem;
    logic [VSQ_W-1:0]     r_den;
    logic [NUM_W-1:0]     r_quot;

    logic [VSQ_W:0] w_rem_sh;
    logic [VSQ_W:0] w_rem_sub;
    logic           w_ge;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        w_rem_sh  = {r_rem, r_quot[NUM_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_den});
        w_rem_sub = w_rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_rem_sub[VSQ_W-1:0] : w_rem_sh[VSQ_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: design/hdr_dp.sv
module hdr_dp import hdr_pkg::*; #(
    parameter int unsigned SHORT_COUNT = SHORT_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_item                 i_item,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output t_result               o_result
);

    // configuration
    logic [DUTY_W-1:0]   r_full_duty;
    logic [DUTY_W-1:0]   r_min_duty;
    logic [DUTY_W-1:0]   r_duty_scale;
    logic [ADC_BITS-1:0] r_short_thr;

    // regulator state
    logic              r_firing, n_firing;
    logic [TVSQ_W-1:0] r_tv_sq, n_tv_sq;
    logic [OC_W-1:0]   r_oc_cnt, n_oc_cnt;
    logic              r_short, n_short;
    logic              r_load, n_load;
    logic              r_found, n_found;
    logic [DUTY_W-1:0] r_duty1, n_duty1;
    logic [DUTY_W-1:0] r_duty2, n_duty2;

    // item and arithmetic
    t_item            r_item;
    t_result          r_res;
    logic [SUP_W-1:0] r_supply;
    logic [NUM_W-1:0] r_num;
    logic [V_W-1:0]   r_v;
    logic [VSQ_W-1:0] r_vsq;

    logic [ADC_BITS-1:0] w_sample;
    logic [VPROD_W-1:0]  w_vprod;
    logic [NUM_W-1:0]    w_div_num;
    logic [VSQ_W-1:0]    w_div_den;
    logic [NUM_W-1:0]    w_quot;
    logic                w_div_done;
    logic [DUTY_W-1:0]   w_duty_new;
    logic                w_oc;
    logic [OC_W-1:0]     w_oc_inc;
    logic                w_ref_zero;
    logic                w_detect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_duty  <= FULL_DUTY_RST;
            r_min_duty   <= MIN_DUTY_RST;
            r_duty_scale <= DUTY_SCALE_RST;
            r_short_thr  <= SHORT_THR_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FULL_DUTY:  r_full_duty  <= i_cfg_data[DUTY_W-1:0];
                CFG_MIN_DUTY:   r_min_duty   <= i_cfg_data[DUTY_W-1:0];
                CFG_DUTY_SCALE: r_duty_scale <= i_cfg_data[DUTY_W-1:0];
                CFG_SHORT_THR:  r_short_thr  <= i_cfg_data[ADC_BITS-1:0];
            endcase
        end
    end

    hdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sup_start | i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_div_num = i_cmd.sup_start ? SUPPLY_NUM : r_num;
    assign w_div_den = i_cmd.sup_start ? VSQ_W'(r_item.ref_sample) : r_vsq;

    assign w_sample = i_cmd.ch ? r_item.ch2_sample : r_item.ch1_sample;
    assign w_vprod  = VPROD_W'(r_supply) * VPROD_W'(w_sample);

    assign w_oc = (r_item.ch1_active && (r_item.ch1_sample < r_short_thr)) ||
                  (r_item.ch2_active && (r_item.ch2_sample < r_short_thr));
    assign w_oc_inc   = (r_oc_cnt == OC_MAX) ? r_oc_cnt : r_oc_cnt + 1'b1;
    assign w_ref_zero = (r_item.ref_sample == '0);
    assign w_detect   = (r_item.ch1_active && (r_item.mode == MODE_ZERO)) ||
                        (r_item.ch2_active && (r_item.mode == MODE_ECO1)) ||
                        (r_item.ch1_active && r_item.ch2_active &&
                         (r_item.mode == MODE_BOOST));

    // clamp of the squared ratio; zero voltage gives full duty
    always_comb begin
        priority if (r_v == '0)
            w_duty_new = r_full_duty;
        else if (w_quot >= NUM_W'(r_full_duty))
            w_duty_new = r_full_duty;
        else if (w_quot < NUM_W'(r_min_duty))
            w_duty_new = r_min_duty;
        else
            w_duty_new = w_quot[DUTY_W-1:0];
    end

    always_comb begin
        n_firing = r_firing;
        n_tv_sq  = r_tv_sq;
        n_oc_cnt = r_oc_cnt;
        n_short  = r_short;
        n_load   = r_load;
        n_found  = r_found;
        n_duty1  = r_duty1;
        n_duty2  = r_duty2;
        if (i_cmd.decide) begin
            n_found = 1'b0;
            unique case (r_item.op)
                OP_START: begin
                    if (!r_firing) begin
                        n_tv_sq = (r_item.mode == MODE_NORMAL) ? TV_SQ_NORMAL : TV_SQ_HIGH;
                        priority if (r_item.mode == MODE_BOOST ||
                                     r_item.mode == MODE_NORMAL) begin
                            n_duty1 = r_full_duty;
                            n_duty2 = r_full_duty;
                        end else if (r_item.mode == MODE_ECO1) begin
                            n_duty1 = r_full_duty;
                            n_duty2 = '0;
                        end else begin
                            n_duty1 = '0;
                            n_duty2 = r_full_duty;
                        end
                        n_load   = 1'b0;
                        n_oc_cnt = '0;
                        n_short  = 1'b0;
                        n_firing = 1'b1;
                    end
                end
                OP_STOP: begin
                    n_firing = 1'b0;
                    n_duty1  = '0;
                    n_duty2  = '0;
                end
                OP_TICK: begin
                    if (r_firing) begin
                        priority if (r_short) begin
                            n_firing = 1'b0;
                            n_duty1  = '0;
                            n_duty2  = '0;
                        end else if (w_oc) begin
                            n_oc_cnt = w_oc_inc;
                            if (w_oc_inc >= OC_W'(SHORT_COUNT)) begin
                                n_short = 1'b1;
                                n_duty1 = '0;
                                n_duty2 = '0;
                            end
                        end else begin
                            n_oc_cnt = '0;
                            if (r_load) begin
                                // no reference reading: full duty on active channels
                                if (r_item.regulate_now && w_ref_zero) begin
                                    if (r_item.ch1_active)
                                        n_duty1 = r_full_duty;
                                    if (r_item.ch2_active)
                                        n_duty2 = r_full_duty;
                                end
                            end else if (w_detect) begin
                                n_load  = 1'b1;
                                n_found = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.write_duty) begin
            if (i_cmd.ch)
                n_duty2 = w_duty_new;
            else
                n_duty1 = w_duty_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_firing <= 1'b0;
            r_tv_sq  <= '0;
            r_oc_cnt <= '0;
            r_short  <= 1'b0;
            r_load   <= 1'b0;
            r_found  <= 1'b0;
            r_duty1  <= '0;
            r_duty2  <= '0;
        end else begin
            r_firing <= n_firing;
            r_tv_sq  <= n_tv_sq;
            r_oc_cnt <= n_oc_cnt;
            r_short  <= n_short;
            r_load   <= n_load;
            r_found  <= n_found;
            r_duty1  <= n_duty1;
            r_duty2  <= n_duty2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take)
            r_item <= i_item;
        if (i_cmd.sup_start)
            r_num <= NUM_W'(r_tv_sq) * NUM_W'(r_duty_scale);
        if (i_cmd.sup_latch)
            r_supply <= w_quot[SUP_W-1:0] + SUPPLY_OFS;
        if (i_cmd.mul_v)
            r_v <= w_vprod[VPROD_W-1:ADC_BITS];
        if (i_cmd.mul_sq)
            r_vsq <= VSQ_W'(r_v) * VSQ_W'(r_v);
        if (i_cmd.push)
            r_res <= '{duty_ch1:       r_duty1,
                       duty_ch2:       r_duty2,
                       short_detected: r_short,
                       load_found:     r_found,
                       firing:         r_firing};
    end

    always_comb begin
        o_stat.need_div = (r_item.op == OP_TICK) && r_firing && !r_short && !w_oc &&
                          r_load && r_item.regulate_now && !w_ref_zero;
        o_stat.ch1_act  = r_item.ch1_active;
        o_stat.ch2_act  = r_item.ch2_active;
        o_stat.v_zero   = (r_v == '0);
        o_stat.div_done = w_div_done;
    end

    assign o_result = r_res;

endmodule

// File: design/hdr_ctrl.sv
module hdr_ctrl import hdr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_ch, n_ch;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            if (o_cmd.push)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        o_cmd    = '0;
        o_cmd.ch = r_ch;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_stat.need_div ? ST_SUP : ST_PUSH;
            end
            ST_SUP: begin
                o_cmd.sup_start = 1'b1;
                n_state         = ST_SUP_WAIT;
            end
            ST_SUP_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.sup_latch = 1'b1;
                    priority if (i_stat.ch1_act) begin
                        n_ch    = 1'b0;
                        n_state = ST_MUL_V;
                    end else if (i_stat.ch2_act) begin
                        n_ch    = 1'b1;
                        n_state = ST_MUL_V;
                    end else begin
                        n_state = ST_PUSH;
                    end
                end
            end
            ST_MUL_V: begin
                o_cmd.mul_v = 1'b1;
                n_state     = ST_MUL_SQ;
            end
            ST_MUL_SQ: begin
                o_cmd.mul_sq = 1'b1;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.v_zero) begin
                    n_state = ST_WRITE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done)
                    n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.write_duty = 1'b1;
                if (!r_ch && i_stat.ch2_act) begin
                    n_ch    = 1'b1;
                    n_state = ST_MUL_V;
                end else begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: design/heater_duty_regulator.sv
// order: a start, stop or plain tick goes from decide straight to the output register;
//   a regulating tick first runs the supply division, then per active channel a multiply,
//   square, divide and clamp, the divide skipped for a channel whose voltage is zero;
//   a full output register stalls the result
// throughput: one item at a time; the next item is taken the cycle after a result is
//   registered; regulating ticks are bound by the shared serial divider
// reset: synchronous, active low; clears the regulator state and loads register defaults
module heater_duty_regulator import hdr_pkg::*; #(
    parameter int unsigned SHORT_COUNT = SHORT_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hdr_item_if.sink              i_item,
    hdr_result_if.source          o_result
);

    // control and status between the sequencer and the datapath
    t_cmd    w_cmd;
    t_stat   w_stat;
    t_item   w_item;
    t_result w_res;
    logic    w_in_ready;
    logic    w_out_valid;

    // incoming item gathered into one word, latched by the datapath on accept
    assign w_item = '{op:           i_item.op,
                      mode:         i_item.mode,
                      ch1_active:   i_item.ch1_active,
                      ch2_active:   i_item.ch2_active,
                      ch1_sample:   i_item.ch1_sample,
                      ch2_sample:   i_item.ch2_sample,
                      ref_sample:   i_item.ref_sample,
                      regulate_now: i_item.regulate_now};

    // sequencer: decide, supply division, then per channel
    // multiply, square, divide and clamp
    hdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // datapath: config registers, regulator state, multipliers and divider
    hdr_dp #(
        .SHORT_COUNT (SHORT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (w_res)
    );

    assign i_item.ready = w_in_ready;

    // output register holds the result while the next item is worked on
    assign o_result.valid          = w_out_valid;
    assign o_result.duty_ch1       = w_res.duty_ch1;
    assign o_result.duty_ch2       = w_res.duty_ch2;
    assign o_result.short_detected = w_res.short_detected;
    assign o_result.load_found     = w_res.load_found;
    assign o_result.firing         = w_res.firing;

endmodule
